FILE: rtl/char_lcd_nibble_write_sequencer_unit_assert.svh
// Assertion macros for the character-LCD nibble write sequencer.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CLNWS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clnws: same-cycle check failed");
`define CLNWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clnws: next-cycle check failed");
`else
`define CLNWS_ASSERT_SAME(label, clk, rst, ante, cons)
`define CLNWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/clnws_pkg.sv
// Types, constants and helpers for the character-LCD nibble write sequencer.
// No dependencies.
package clnws_pkg;

   localparam int DELAY_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [31:0] DELAY_MAX = 32'((64'd1 << DELAY_BITS) - 64'd1);

   localparam logic [7:0] CURSOR_CMD  = 8'h80;
   localparam logic [7:0] CURSOR_ROW2 = 8'h40;
   localparam logic [7:0] ROW_ONE     = 8'd1;
   localparam logic [7:0] ROW_TWO     = 8'd2;

   localparam logic [7:0]  TICKS_PER_US_RESET = 8'd1;
   localparam logic [15:0] CURSOR_DELAY_RESET = 16'd50;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_UPPER  = 2'd2,
      OP_CURSOR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_LEAD  = 2'd1,
      PHASE_HIGH  = 2'd2,
      PHASE_TRAIL = 2'd3
   } phase_type;

   typedef enum logic {
      REG_TICKS_PER_US = 1'b0,
      REG_CURSOR_DELAY = 1'b1
   } reg_index_type;

   // saturate to the counter width, zero counts as one
   function automatic logic [DELAY_BITS-1:0] delay_limit(input logic [15:0] d);
      logic [31:0] w;
      w = 32'(d);
      if (w > DELAY_MAX) w = DELAY_MAX;
      if (w == 32'd0) w = 32'd1;
      return w[DELAY_BITS-1:0];
   endfunction

endpackage

FILE: rtl/char_lcd_nibble_write_sequencer_unit.sv
// Host side of a 4-bit character-LCD bus: nibble sequencing and phase timing.
// Depends on clnws_pkg and char_lcd_nibble_write_sequencer_unit_assert.svh.
//
// Usage:
//  req_ beats carry a kind in tuser (tick, full byte write, upper-nibble write,
//  cursor move) and the command fields in tdata. Ticks advance the phase timer;
//  a command is taken only while idle and is otherwise dropped and flagged.
//  Every request beat yields exactly one rsp_ beat with the pin levels, busy
//  and reject flag as they stand after that beat.
//  The state update and the result register load happen at the edge that
//  accepts the request. Throughput is one beat per cycle, set by the single
//  state register loop; req_tready stays high while the result register is
//  empty or being drained in the same cycle.
//  When the receiver stalls, the result is held and req_tready drops until the
//  result is taken; no beat is lost. Synchronous reset returns to idle with
//  all pins low, ticks_per_us = 1 and cursor_delay_us = 50. The user must write
//  the CSR port (APB-style) only while idle; the block does not enforce it.
`include "char_lcd_nibble_write_sequencer_unit_assert.svh"

module char_lcd_nibble_write_sequencer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] byte_value, [8] reg_select, [24:9] delay_us, [32:25] row,
   // [40:33] col, [47:41] zero
   input  logic [clnws_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [1:0] op
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] enable_pin, [1] select_pin, [5:2] data_pins, [6] busy_res, [7] rejected
   output logic [clnws_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [clnws_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import clnws_pkg::*;

   // request fields
   op_type      req_op;
   logic [7:0]  req_byte;
   logic        req_rs;
   logic [15:0] req_delay;
   logic [7:0]  req_row;
   logic [7:0]  req_col;
   logic        req_accept;

   // config
   logic [7:0]  ticks_per_us_ff, ticks_per_us_in;
   logic [15:0] cursor_delay_ff, cursor_delay_in;
   logic        csr_write;
   reg_index_type csr_index;

   // sequencer state
   phase_type             phase_ff, phase_in;
   logic                  pending_ff, pending_in;
   logic [8:0]            held_ff, held_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic [DELAY_BITS-1:0] us_ff, us_in;
   logic [7:0]            prescale_ff, prescale_in;
   logic                  enable_ff, enable_in;
   logic                  select_ff, select_in;
   logic [3:0]            nibble_ff, nibble_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // next-state scratch
   logic                  rejected;
   logic [7:0]            tpu;
   logic [7:0]            prescale_inc;
   logic [DELAY_BITS-1:0] us_dec;
   logic                  start_go;
   logic [7:0]            start_byte;
   logic                  start_rs;
   logic [15:0]           start_delay;
   logic                  start_full;
   logic [7:0]            cursor_addr;

   assign req_op     = op_type'(req_tuser);
   assign req_byte   = req_tdata[7:0];
   assign req_rs     = req_tdata[8];
   assign req_delay  = req_tdata[24:9];
   assign req_row    = req_tdata[32:25];
   assign req_col    = req_tdata[40:33];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      ticks_per_us_in = ticks_per_us_ff;
      cursor_delay_in = cursor_delay_ff;
      if (csr_write) begin
         case (csr_index)
            REG_TICKS_PER_US: ticks_per_us_in = csr_pwdata[7:0];
            REG_CURSOR_DELAY: cursor_delay_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TICKS_PER_US: csr_prdata = 32'(ticks_per_us_ff);
         REG_CURSOR_DELAY: csr_prdata = 32'(cursor_delay_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   // sequencer next state and result
   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      held_in     = held_ff;
      delay_in    = delay_ff;
      us_in       = us_ff;
      prescale_in = prescale_ff;
      enable_in   = enable_ff;
      select_in   = select_ff;
      nibble_in   = nibble_ff;
      rejected    = 1'b0;
      start_go    = 1'b0;
      start_byte  = req_byte;
      start_rs    = req_rs;
      start_delay = req_delay;
      start_full  = 1'b1;

      tpu          = (ticks_per_us_ff == 8'd0) ? 8'd1 : ticks_per_us_ff;
      prescale_inc = prescale_ff + 8'd1;
      us_dec       = (us_ff != '0) ? us_ff - DELAY_BITS'(1) : us_ff;
      cursor_addr  = (req_col - 8'd1) | CURSOR_CMD;
      if (req_row == ROW_TWO) cursor_addr = cursor_addr | CURSOR_ROW2;

      if (req_accept) begin
         case (req_op)
            OP_TICK: begin
               if (phase_ff != PHASE_IDLE) begin
                  prescale_in = prescale_inc;
                  if (prescale_inc >= tpu || prescale_inc == 8'd0) begin
                     prescale_in = 8'd0;
                     us_in       = us_dec;
                     if (us_dec == '0) begin
                        us_in = delay_ff;
                        case (phase_ff)
                           PHASE_LEAD: begin
                              select_in = held_ff[8];
                              nibble_in = held_ff[7:4];
                              enable_in = 1'b1;
                              phase_in  = PHASE_HIGH;
                           end
                           PHASE_HIGH: begin
                              enable_in = 1'b0;
                              phase_in  = PHASE_TRAIL;
                           end
                           PHASE_TRAIL: begin
                              if (pending_ff) begin
                                 pending_in = 1'b0;
                                 held_in    = {held_ff[8], held_ff[3:0], 4'b0000};
                                 enable_in  = 1'b0;
                                 phase_in   = PHASE_LEAD;
                              end else begin
                                 phase_in = PHASE_IDLE;
                                 us_in    = us_dec;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
               end
            end
            OP_WRITE, OP_UPPER: begin
               if (phase_ff != PHASE_IDLE) begin
                  rejected = 1'b1;
               end else begin
                  start_go   = 1'b1;
                  start_full = (req_op == OP_WRITE);
               end
            end
            OP_CURSOR: begin
               if (phase_ff != PHASE_IDLE) begin
                  rejected = 1'b1;
               end else if (req_row == ROW_ONE || req_row == ROW_TWO) begin
                  start_go    = 1'b1;
                  start_byte  = cursor_addr;
                  start_rs    = 1'b0;
                  start_delay = cursor_delay_ff;
               end
            end
            default: ;
         endcase
      end

      if (start_go) begin
         held_in     = {start_rs, start_byte};
         pending_in  = start_full;
         delay_in    = delay_limit(start_delay);
         us_in       = delay_limit(start_delay);
         prescale_in = 8'd0;
         enable_in   = 1'b0;
         phase_in    = PHASE_LEAD;
      end

      rsp_data_in = {rejected, (phase_in != PHASE_IDLE), nibble_in, select_in, enable_in};

      if (req_accept) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff <= TICKS_PER_US_RESET;
         cursor_delay_ff <= CURSOR_DELAY_RESET;
         phase_ff        <= PHASE_IDLE;
         pending_ff      <= 1'b0;
         held_ff         <= '0;
         delay_ff        <= '0;
         us_ff           <= '0;
         prescale_ff     <= '0;
         enable_ff       <= 1'b0;
         select_ff       <= 1'b0;
         nibble_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         ticks_per_us_ff <= ticks_per_us_in;
         cursor_delay_ff <= cursor_delay_in;
         phase_ff        <= phase_in;
         pending_ff      <= pending_in;
         held_ff         <= held_in;
         delay_ff        <= delay_in;
         us_ff           <= us_in;
         prescale_ff     <= prescale_in;
         enable_ff       <= enable_in;
         select_ff       <= select_in;
         nibble_ff       <= nibble_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `CLNWS_ASSERT_SAME(a_idle_no_pending, clock, reset, phase_ff == PHASE_IDLE, !pending_ff)
   `CLNWS_ASSERT_SAME(a_enable_in_high, clock, reset, enable_ff, phase_ff == PHASE_HIGH)
   `CLNWS_ASSERT_SAME(a_us_bounded, clock, reset, phase_ff != PHASE_IDLE, us_ff <= delay_ff)
   `CLNWS_ASSERT_NEXT(a_busy_reject, clock, reset, req_accept && req_tuser != OP_TICK && phase_ff != PHASE_IDLE, rsp_valid_ff && rsp_data_ff[7] && rsp_data_ff[6])

endmodule
